// File: rtl/core/egcd_pkg.sv
package egcd_pkg;

    // default operand width
    localparam int OPERAND_BITS_DEF = 31;

    // datapath operations, one per control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUB_FIRST,
        OP_SUB_AGAIN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SHIFT,
        OP_EMIT
    } egcd_op_t;

    // branch conditions: taken goes to the target, otherwise to the next step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SMALL_ZERO,
        COND_FITS,
        COND_DIV_MORE,
        COND_OUT_BLOCKED
    } egcd_cond_t;

    typedef logic [3:0] upc_t;

    // program addresses
    localparam upc_t UPC_EMIT     = 4'd0;
    localparam upc_t UPC_IDLE     = 4'd1;
    localparam upc_t UPC_CHECK    = 4'd2;
    localparam upc_t UPC_SUB1     = 4'd3;
    localparam upc_t UPC_SUB2     = 4'd4;
    localparam upc_t UPC_SUB3     = 4'd5;
    localparam upc_t UPC_DIV_INIT = 4'd6;
    localparam upc_t UPC_DIV_STEP = 4'd7;
    localparam upc_t UPC_SHIFT    = 4'd8;

    typedef struct packed {
        egcd_op_t   op;
        egcd_cond_t cond;
        upc_t       target;
    } ucode_t;

    // flags from the datapath to the sequencer
    typedef struct packed {
        logic small_zero;
        logic fits;
        logic div_more;
    } egcd_status_t;

    // control store
    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        unique case (pc)
            UPC_EMIT:     w = '{op: OP_EMIT,      cond: COND_OUT_BLOCKED, target: UPC_EMIT};
            UPC_IDLE:     w = '{op: OP_LOAD,      cond: COND_NO_INPUT,    target: UPC_IDLE};
            UPC_CHECK:    w = '{op: OP_NONE,      cond: COND_SMALL_ZERO,  target: UPC_EMIT};
            UPC_SUB1:     w = '{op: OP_SUB_FIRST, cond: COND_FITS,        target: UPC_SHIFT};
            UPC_SUB2:     w = '{op: OP_SUB_AGAIN, cond: COND_FITS,        target: UPC_SHIFT};
            UPC_SUB3:     w = '{op: OP_SUB_AGAIN, cond: COND_FITS,        target: UPC_SHIFT};
            UPC_DIV_INIT: w = '{op: OP_DIV_INIT,  cond: COND_NEVER,       target: UPC_IDLE};
            UPC_DIV_STEP: w = '{op: OP_DIV_STEP,  cond: COND_DIV_MORE,    target: UPC_DIV_STEP};
            UPC_SHIFT:    w = '{op: OP_SHIFT,     cond: COND_ALWAYS,      target: UPC_CHECK};
            default:      w = '{op: OP_NONE,      cond: COND_ALWAYS,      target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/egcd_datapath.sv
module egcd_datapath #(
    parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
) (
    input  logic                     aclk,
    input  egcd_pkg::egcd_op_t       op,
    input  logic [OPERAND_BITS-1:0]  first_value,
    input  logic [OPERAND_BITS-1:0]  second_value,
    output egcd_pkg::egcd_status_t   status,
    output logic [OPERAND_BITS-1:0]  divisor,
    output logic                     zero_operand
);

    localparam int CW = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(OPERAND_BITS - 1);

    logic [OPERAND_BITS-1:0] big_reg, big_next;
    logic [OPERAND_BITS-1:0] small_reg, small_next;
    logic [OPERAND_BITS-1:0] rem_reg, rem_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    zero_reg, zero_next;

    logic [OPERAND_BITS-1:0] diff_src;
    logic [OPERAND_BITS-1:0] diff;
    logic [OPERAND_BITS:0]   part;
    logic [OPERAND_BITS:0]   part_sub;
    logic                    part_ge;

    // subtract stage: first pass from big, later passes from the running difference
    assign diff_src = (op == egcd_pkg::OP_SUB_FIRST) ? big_reg : rem_reg;
    assign diff     = diff_src - small_reg;

    // restoring remainder: big shifts out msb first into rem
    assign part     = {rem_reg, big_reg[OPERAND_BITS-1]};
    assign part_ge  = part >= {1'b0, small_reg};
    assign part_sub = part - {1'b0, small_reg};

    assign status.small_zero = (small_reg == '0);
    assign status.fits       = (diff <= small_reg);
    assign status.div_more   = (cnt_reg != CNT_LAST);

    assign divisor      = big_reg;
    assign zero_operand = zero_reg;

    always_comb begin
        big_next   = big_reg;
        small_next = small_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        case (op)
            egcd_pkg::OP_LOAD: begin
                if (first_value >= second_value) begin
                    big_next   = first_value;
                    small_next = second_value;
                end else begin
                    big_next   = second_value;
                    small_next = first_value;
                end
                zero_next = (first_value == '0) || (second_value == '0);
            end
            egcd_pkg::OP_SUB_FIRST,
            egcd_pkg::OP_SUB_AGAIN: begin
                rem_next = diff;
            end
            egcd_pkg::OP_DIV_INIT: begin
                rem_next = '0;
                cnt_next = '0;
            end
            egcd_pkg::OP_DIV_STEP: begin
                rem_next = part_ge ? part_sub[OPERAND_BITS-1:0] : part[OPERAND_BITS-1:0];
                big_next = big_reg << 1;
                cnt_next = cnt_reg + 1'b1;
            end
            egcd_pkg::OP_SHIFT: begin
                big_next   = small_reg;
                small_next = rem_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        big_reg   <= big_next;
        small_reg <= small_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        zero_reg  <= zero_next;
    end

endmodule

// File: rtl/core/euclid_gcd_subtract_first.sv
// sequence: the idle step takes a pair; each euclid round tries up to three subtractions and
// falls back to a bit-serial remainder, then shifts, until the smaller value is zero
// throughput: one pair in flight, the next taken in the idle step after the emit step;
// a held result stalls the emit step
// reset: synchronous active-low aresetn returns the sequencer to idle and empties the
// result register; operand and result payload registers are not cleared
module euclid_gcd_subtract_first #(
    parameter  int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF,
    localparam int S_WIDTH      = ((2 * OPERAND_BITS + 7) / 8) * 8,
    localparam int M_WIDTH      = ((OPERAND_BITS + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // first_value [OPERAND_BITS-1:0], second_value [2*OPERAND_BITS-1:OPERAND_BITS]
    input  logic [S_WIDTH-1:0]           s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // divisor [OPERAND_BITS-1:0]
    output logic [M_WIDTH-1:0]           m_tdata,
    // zero_operand [0]
    output logic                         m_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready
);

    egcd_pkg::upc_t          upc_reg, upc_next;
    egcd_pkg::ucode_t        uword;
    egcd_pkg::egcd_op_t      dp_op;
    egcd_pkg::egcd_status_t  status;
    logic                    taken;
    logic                    s_accept;
    logic                    out_blocked;
    logic                    emit;

    logic [OPERAND_BITS-1:0] dp_divisor;
    logic                    dp_zero;

    // result register, parts the sequencer from the output transaction
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OPERAND_BITS-1:0] divisor_reg, divisor_next;
    logic                    zero_reg, zero_next;

    // control word for the current step
    assign uword = egcd_pkg::ucode_rom(upc_reg);

    assign s_tready    = (uword.op == egcd_pkg::OP_LOAD);
    assign s_accept    = s_tvalid && s_tready;
    assign out_blocked = m_tvalid_reg && !m_tready;
    assign emit        = (uword.op == egcd_pkg::OP_EMIT) && !out_blocked;

    // branch evaluation and datapath op gating
    always_comb begin
        unique case (uword.cond)
            egcd_pkg::COND_NEVER:       taken = 1'b0;
            egcd_pkg::COND_ALWAYS:      taken = 1'b1;
            egcd_pkg::COND_NO_INPUT:    taken = !s_tvalid;
            egcd_pkg::COND_SMALL_ZERO:  taken = status.small_zero;
            egcd_pkg::COND_FITS:        taken = status.fits;
            egcd_pkg::COND_DIV_MORE:    taken = status.div_more;
            egcd_pkg::COND_OUT_BLOCKED: taken = out_blocked;
            default:                    taken = 1'b1;
        endcase

        upc_next = taken ? uword.target : upc_reg + 1'b1;

        // load only on an accepted transaction; emit is handled here, not in the datapath
        dp_op = uword.op;
        if ((uword.op == egcd_pkg::OP_LOAD) && !s_accept) begin
            dp_op = egcd_pkg::OP_NONE;
        end
        if (uword.op == egcd_pkg::OP_EMIT) begin
            dp_op = egcd_pkg::OP_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= egcd_pkg::UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    egcd_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .op           (dp_op),
        .first_value  (s_tdata[OPERAND_BITS-1:0]),
        .second_value (s_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
        .status       (status),
        .divisor      (dp_divisor),
        .zero_operand (dp_zero)
    );

    // output register: a new result is taken when the old one has gone or is going
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        divisor_next  = divisor_reg;
        zero_next     = zero_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (emit) begin
            m_tvalid_next = 1'b1;
            divisor_next  = dp_divisor;
            zero_next     = dp_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        divisor_reg <= divisor_next;
        zero_reg    <= zero_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_WIDTH'(divisor_reg);
    assign m_tuser  = zero_reg;

endmodule

// File: rtl/core/egcd_checker.sv
module egcd_checker #(
    parameter int OPERAND_BITS = egcd_pkg::OPERAND_BITS_DEF
) (
    input logic                                      aclk,
    input logic                                      aresetn,
    input logic                                      s_tvalid,
    input logic                                      s_tready,
    input logic [((OPERAND_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                                      m_tuser,
    input logic                                      m_tvalid,
    input logic                                      m_tready
);

    // result channel empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one pair at a time: busy after a transaction is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // a zero divisor only comes from zero operands
    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[OPERAND_BITS-1:0] == '0) |-> m_tuser)
        else $error("zero divisor without zero flag");

endmodule

bind euclid_gcd_subtract_first egcd_checker #(
    .OPERAND_BITS (OPERAND_BITS)
) u_egcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
